// ===== hw/rtl/pmbw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pmbw_pkg;

  localparam logic [1:0] OP_PROGRAM = 2'd0;
  localparam logic [1:0] OP_HEADER  = 2'd1;
  localparam logic [1:0] OP_DATA    = 2'd2;

  localparam logic [2:0] ST_ENTRY_SET      = 3'd0;
  localparam logic [2:0] ST_ACCEPTED       = 3'd1;
  localparam logic [2:0] ST_NO_MATCH       = 3'd2;
  localparam logic [2:0] ST_OUT_OF_RANGE   = 3'd3;
  localparam logic [2:0] ST_BYTE_WRITTEN   = 3'd4;
  localparam logic [2:0] ST_BYTE_DISCARDED = 3'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  entry_index;
    logic        entry_enable;
    logic [15:0] from_port;
    logic [15:0] to_port;
    logic [31:0] start_offset;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] matched_index;
    logic [9:0] write_offset;
  } out_res_t;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dst;
  } port_pair_t;

  typedef struct packed {
    logic       en;
    logic       valid;
    port_pair_t pair;
  } tbl_wr_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pmbw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pmbw_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmbw_table #(
  parameter int NUM_ENTRIES = 16,
  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pmbw_pkg::tbl_wr_t      wr,
  input  wire logic [IDX_W-1:0]       wr_idx,
  input  wire logic                   go,
  input  wire pmbw_pkg::port_pair_t   key,
  output pmbw_pkg::scan_stat_t        stat,
  output logic      [IDX_W-1:0]       hit_idx
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP} state_t;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_ENTRIES - 1);

  state_t                  state_r;
  logic [IDX_W-1:0]        ptr_r;
  logic [NUM_ENTRIES-1:0]  valid_r;
  pmbw_pkg::scan_stat_t    stat_r;
  logic [IDX_W-1:0]        hit_r;
  pmbw_pkg::port_pair_t    rd_pair;
  logic                    hit_now;

  pmbw_ram #(
    .WIDTH ($bits(pmbw_pkg::port_pair_t)),
    .DEPTH (NUM_ENTRIES)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr_idx),
    .wr_data (wr.pair),
    .rd_en   (state_r == S_READ),
    .rd_addr (ptr_r),
    .rd_data (rd_pair)
  );

  // shared compare unit: one entry per visit
  assign hit_now = valid_r[ptr_r] && (rd_pair == key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ptr_r   <= '0;
      valid_r <= '0;
      stat_r  <= '0;
    end else begin
      if (wr.en) begin
        valid_r[wr_idx] <= wr.valid;
      end
      unique case (state_r)
        S_IDLE: begin
          stat_r.done <= 1'b0;
          if (go) begin
            ptr_r   <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          stat_r.done <= 1'b0;
          state_r     <= S_CMP;
        end
        S_CMP: begin
          if (hit_now) begin
            stat_r  <= '{done: 1'b1, found: 1'b1};
            hit_r   <= ptr_r;
            state_r <= S_IDLE;
          end else if (ptr_r == LAST) begin
            stat_r  <= '{done: 1'b1, found: 1'b0};
            state_r <= S_IDLE;
          end else begin
            stat_r.done <= 1'b0;
            ptr_r       <= ptr_r + 1'b1;
            state_r     <= S_READ;
          end
        end
        default: begin
          stat_r.done <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign stat    = stat_r;
  assign hit_idx = hit_r;

endmodule

`default_nettype wire

// ===== hw/rtl/port_matched_buffer_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                    Handshake
// request   start, busy, in_req      taken when start is high and busy is low
// result    out_valid, out_res       one-cycle strobe, always taken
//
// Program and data results come in the cycle after the request; unused ones give none.
// A header scans the entry table through one compare unit, each entry by a
// registered table read, then a compare; a hit in slot k ends the scan there, a miss
// visits every entry, and the result appears in the cycle busy falls.
// Synchronous active-low reset clears the table valid bits and any open packet.
// The receiver cannot stall; busy is the only back-pressure.

module port_matched_buffer_writer #(
  parameter int NUM_ENTRIES  = 16,
  parameter int BUFFER_BYTES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire pmbw_pkg::in_req_t in_req,
  output logic                   busy,
  output logic                   out_valid,
  output pmbw_pkg::out_res_t     out_res
);

  localparam int IDX_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int OFF_W     = $clog2(BUFFER_BYTES + 1);
  localparam int BUF_DEPTH = NUM_ENTRIES * BUFFER_BYTES;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  typedef enum logic {T_IDLE, T_SCAN} state_t;

  state_t                 state_r;
  logic                   out_valid_r;
  pmbw_pkg::out_res_t     out_res_r;
  logic                   open_r;
  logic [IDX_W-1:0]       cur_idx_r;
  logic [OFF_W-1:0]       next_off_r;
  logic [15:0]            bytes_left_r;
  pmbw_pkg::port_pair_t   key_r;
  logic [31:0]            off_r;
  logic [15:0]            len_r;

  logic                   accept;
  logic                   prog_ok;
  pmbw_pkg::tbl_wr_t      tbl_wr;
  logic                   scan_go;
  pmbw_pkg::scan_stat_t   scan_stat;
  logic [IDX_W-1:0]       hit_idx;
  logic [32:0]            range_sum;
  logic                   out_of_range;
  logic                   buf_we;
  logic [BUF_AW-1:0]      buf_addr;

  assign busy   = (state_r == T_SCAN);
  assign accept = start && !busy;

  assign prog_ok     = 32'(in_req.entry_index) < NUM_ENTRIES;
  assign tbl_wr.en   = accept && (in_req.opcode == pmbw_pkg::OP_PROGRAM) && prog_ok;
  assign tbl_wr.valid = in_req.entry_enable;
  assign tbl_wr.pair = '{src: in_req.from_port, dst: in_req.to_port};
  assign scan_go     = accept && (in_req.opcode == pmbw_pkg::OP_HEADER);

  pmbw_table #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .wr_idx  (IDX_W'(in_req.entry_index)),
    .go      (scan_go),
    .key     (key_r),
    .stat    (scan_stat),
    .hit_idx (hit_idx)
  );

  assign range_sum    = {1'b0, off_r} + 33'(len_r);
  assign out_of_range = range_sum > 33'(BUFFER_BYTES);

  assign buf_we   = accept && (in_req.opcode == pmbw_pkg::OP_DATA) && open_r;
  assign buf_addr = BUF_AW'(cur_idx_r) * BUF_AW'(BUFFER_BYTES) + BUF_AW'(next_off_r);

  pmbw_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buffers (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (buf_addr),
    .wr_data (in_req.payload_byte),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      open_r      <= 1'b0;
    end else begin
      unique case (state_r)
        T_IDLE: begin
          if (start) begin
            unique case (in_req.opcode)
              pmbw_pkg::OP_PROGRAM: begin
                out_valid_r <= 1'b1;
                out_res_r   <= '{status: pmbw_pkg::ST_ENTRY_SET,
                                 matched_index: in_req.entry_index,
                                 write_offset: '0};
              end
              pmbw_pkg::OP_HEADER: begin
                out_valid_r <= 1'b0;
                key_r   <= '{src: in_req.from_port, dst: in_req.to_port};
                off_r   <= in_req.start_offset;
                len_r   <= in_req.payload_length;
                open_r  <= 1'b0;
                state_r <= T_SCAN;
              end
              pmbw_pkg::OP_DATA: begin
                out_valid_r <= 1'b1;
                if (open_r) begin
                  out_res_r    <= '{status: pmbw_pkg::ST_BYTE_WRITTEN,
                                    matched_index: 4'(cur_idx_r),
                                    write_offset: 10'(next_off_r)};
                  next_off_r   <= next_off_r + 1'b1;
                  bytes_left_r <= bytes_left_r - 1'b1;
                  if (bytes_left_r == 16'd1) begin
                    open_r <= 1'b0;
                  end
                end else begin
                  out_res_r <= '{status: pmbw_pkg::ST_BYTE_DISCARDED,
                                 matched_index: '0, write_offset: '0};
                end
              end
              default: begin
                out_valid_r <= 1'b0;
              end
            endcase
          end else begin
            out_valid_r <= 1'b0;
          end
        end
        T_SCAN: begin
          if (scan_stat.done) begin
            out_valid_r <= 1'b1;
            state_r     <= T_IDLE;
            if (!scan_stat.found) begin
              out_res_r <= '{status: pmbw_pkg::ST_NO_MATCH,
                             matched_index: '0, write_offset: '0};
            end else if (out_of_range) begin
              out_res_r <= '{status: pmbw_pkg::ST_OUT_OF_RANGE,
                             matched_index: 4'(hit_idx), write_offset: '0};
            end else begin
              out_res_r    <= '{status: pmbw_pkg::ST_ACCEPTED,
                                matched_index: 4'(hit_idx),
                                write_offset: 10'(off_r)};
              cur_idx_r    <= hit_idx;
              next_off_r   <= OFF_W'(off_r);
              bytes_left_r <= len_r;
              open_r       <= (len_r != 16'd0);
            end
          end else begin
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pmbw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmbw_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire pmbw_pkg::in_req_t  in_req,
  input wire logic               out_valid,
  input wire pmbw_pkg::out_res_t out_res
);

  logic acc;
  assign acc = start && !busy;

  a_header_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req.opcode == pmbw_pkg::OP_HEADER) |=> busy && !out_valid)
    else $error("header request did not start a table scan");

  a_program_echo: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req.opcode == pmbw_pkg::OP_PROGRAM) |=>
      out_valid && (out_res.status == pmbw_pkg::ST_ENTRY_SET) &&
      (out_res.matched_index == $past(in_req.entry_index)))
    else $error("program request result wrong");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc) || $past(busy))
    else $error("result without a request");

  a_unused_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_req.opcode != pmbw_pkg::OP_PROGRAM) &&
    (in_req.opcode != pmbw_pkg::OP_HEADER) &&
    (in_req.opcode != pmbw_pkg::OP_DATA) |=> !out_valid && !busy)
    else $error("unused opcode produced activity");

  a_discard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_res.status == pmbw_pkg::ST_BYTE_DISCARDED) ||
                  (out_res.status == pmbw_pkg::ST_NO_MATCH)) |->
      (out_res.matched_index == 4'd0) && (out_res.write_offset == 10'd0))
    else $error("dropped request carries slot or offset");

endmodule

bind port_matched_buffer_writer pmbw_checker u_pmbw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

`default_nettype wire

// ===== tb/port_matched_buffer_writer_tb.sv =====
`timescale 1ns / 1ps

module port_matched_buffer_writer_tb;

  localparam int NUM_ENTRIES  = 16;
  localparam int BUFFER_BYTES = 1024;
  localparam int HDR_LATENCY  = 2 * NUM_ENTRIES + 3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic               clk    = 1'b0;
  logic               rst_n  = 1'b0;
  logic               start  = 1'b0;
  pmbw_pkg::in_req_t  in_req = '0;
  logic               busy;
  logic               out_valid;
  pmbw_pkg::out_res_t out_res;

  port_matched_buffer_writer #(
    .NUM_ENTRIES  (NUM_ENTRIES),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  logic [15:0] tbl_src   [NUM_ENTRIES];
  logic [15:0] tbl_dst   [NUM_ENTRIES];
  logic        tbl_valid [NUM_ENTRIES];
  logic        pkt_open;
  logic [3:0]  pkt_slot;
  int unsigned pkt_off;
  int unsigned pkt_left;

  logic [15:0] pool_src [8];
  logic [15:0] pool_dst [8];

  pmbw_pkg::out_res_t exp_res_q[$];
  int       err_cnt   = 0;
  int       cycle_cnt = 0;
  int       sent_reqs = 0;
  bit       gaps_on;
  int       gap_pct;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_mirror();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_src[i]   = '0;
      tbl_dst[i]   = '0;
      tbl_valid[i] = 1'b0;
    end
    pkt_open = 1'b0;
    pkt_slot = '0;
    pkt_off  = 0;
    pkt_left = 0;
  endfunction

  function automatic bit predict_req(input pmbw_pkg::in_req_t r,
                                     output pmbw_pkg::out_res_t res);
    int         hit;
    logic [32:0] span;
    res = '0;
    hit = -1;
    case (r.opcode)
      pmbw_pkg::OP_PROGRAM: begin
        tbl_src[r.entry_index]   = r.from_port;
        tbl_dst[r.entry_index]   = r.to_port;
        tbl_valid[r.entry_index] = r.entry_enable;
        res.status        = pmbw_pkg::ST_ENTRY_SET;
        res.matched_index = r.entry_index;
        return 1'b1;
      end
      pmbw_pkg::OP_HEADER: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (hit < 0 && tbl_valid[i] && tbl_src[i] == r.from_port &&
              tbl_dst[i] == r.to_port) begin
            hit = i;
          end
        end
        pkt_open = 1'b0;
        pkt_left = 0;
        span = {1'b0, r.start_offset} + {17'd0, r.payload_length};
        if (hit < 0) begin
          res.status = pmbw_pkg::ST_NO_MATCH;
        end else if (span > BUFFER_BYTES) begin
          res.status        = pmbw_pkg::ST_OUT_OF_RANGE;
          res.matched_index = hit[3:0];
        end else begin
          pkt_slot = hit[3:0];
          pkt_off  = r.start_offset;
          pkt_left = 32'(r.payload_length);
          pkt_open = (pkt_left != 0);
          res.status        = pmbw_pkg::ST_ACCEPTED;
          res.matched_index = hit[3:0];
          res.write_offset  = r.start_offset[9:0];
        end
        return 1'b1;
      end
      pmbw_pkg::OP_DATA: begin
        if (pkt_open && pkt_left != 0 && pkt_off < BUFFER_BYTES) begin
          res.status        = pmbw_pkg::ST_BYTE_WRITTEN;
          res.matched_index = pkt_slot;
          res.write_offset  = pkt_off[9:0];
          pkt_off++;
          pkt_left--;
          if (pkt_left == 0) pkt_open = 1'b0;
        end else begin
          pkt_open   = 1'b0;
          res.status = pmbw_pkg::ST_BYTE_DISCARDED;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input pmbw_pkg::out_res_t want,
                                 input pmbw_pkg::out_res_t got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s: expected status %0d slot %0d offset %0d, got status %0d slot %0d offset %0d",
               what, want.status, want.matched_index, want.write_offset,
               got.status, got.matched_index, got.write_offset);
    end
  endtask

  // check results first, then predict the request taken at this edge
  always @(posedge clk) begin
    pmbw_pkg::out_res_t want;
    pmbw_pkg::out_res_t pred;
    if (!rst_n) begin
      clear_mirror();
      exp_res_q.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (exp_res_q.size() == 0) begin
          report_mismatch("unexpected result", '0, out_res);
        end else begin
          want = exp_res_q.pop_front();
          if (out_valid !== 1'b1 || out_res.status !== want.status ||
              out_res.matched_index !== want.matched_index ||
              out_res.write_offset !== want.write_offset) begin
            report_mismatch("result mismatch", want, out_res);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (predict_req(in_req, pred)) exp_res_q = {exp_res_q, pred};
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic pmbw_pkg::in_req_t mk_base();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(pmbw_pkg::in_req_t)-1:0];
  endfunction

  function automatic pmbw_pkg::in_req_t mk_program(input logic [3:0] idx, input logic en,
                                                   input logic [15:0] sp,
                                                   input logic [15:0] dp);
    pmbw_pkg::in_req_t r;
    r = mk_base();
    r.opcode       = pmbw_pkg::OP_PROGRAM;
    r.entry_index  = idx;
    r.entry_enable = en;
    r.from_port    = sp;
    r.to_port      = dp;
    return r;
  endfunction

  function automatic pmbw_pkg::in_req_t mk_header(input logic [15:0] sp,
                                                  input logic [15:0] dp,
                                                  input logic [31:0] off,
                                                  input logic [15:0] len);
    pmbw_pkg::in_req_t r;
    r = mk_base();
    r.opcode         = pmbw_pkg::OP_HEADER;
    r.from_port      = sp;
    r.to_port        = dp;
    r.start_offset   = off;
    r.payload_length = len;
    return r;
  endfunction

  function automatic pmbw_pkg::in_req_t mk_data(input logic [7:0] b);
    pmbw_pkg::in_req_t r;
    r = mk_base();
    r.opcode       = pmbw_pkg::OP_DATA;
    r.payload_byte = b;
    return r;
  endfunction

  function automatic pmbw_pkg::in_req_t mk_op(input logic [1:0] op);
    pmbw_pkg::in_req_t r;
    r = mk_base();
    r.opcode = op;
    return r;
  endfunction

  task automatic send_req(input pmbw_pkg::in_req_t r);
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    if (r.opcode != OP_UNUSED) sent_reqs++;
  endtask

  task automatic idle_gap(input int n);
    start  <= 1'b0;
    in_req <= mk_base();
    repeat (n) @(posedge clk);
  endtask

  task automatic issue(input pmbw_pkg::in_req_t r);
    send_req(r);
    if (gaps_on && $urandom_range(99) < gap_pct) idle_gap($urandom_range(8, 1));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (exp_res_q.size() != 0) @(posedge clk);
  endtask

  task automatic program_from_pool(input logic [3:0] idx);
    int p;
    p = $urandom_range(7);
    issue(mk_program(idx, $urandom_range(99) < 75, pool_src[p], pool_dst[p]));
  endtask

  task automatic send_packet();
    int          k;
    int          p;
    int unsigned len;
    int unsigned n;
    logic [31:0] off;
    logic [15:0] sp;
    logic [15:0] dp;
    bit          oor;
    k  = $urandom_range(NUM_ENTRIES - 1);
    sp = tbl_src[k];
    dp = tbl_dst[k];
    if ($urandom_range(9) == 0) begin
      p  = $urandom_range(7);
      sp = pool_src[p];
      dp = pool_dst[$urandom_range(7)];
    end
    p = $urandom_range(99);
    if (p < 8) len = 0;
    else if (p < 90) len = $urandom_range(12, 1);
    else len = $urandom_range(80, 13);
    p   = $urandom_range(99);
    oor = (p < 10);
    if (oor) begin
      if ($urandom_range(1)) begin
        off = BUFFER_BYTES - len + $urandom_range(300, 1);
      end else begin
        off = $urandom();
        if (off < BUFFER_BYTES + 1) off = BUFFER_BYTES + 1;
      end
    end else if (p < 25) begin
      off = BUFFER_BYTES - len;
    end else begin
      off = $urandom_range(BUFFER_BYTES - len);
    end
    issue(mk_header(sp, dp, off, len[15:0]));
    if (oor) n = $urandom_range(3);
    else if (len > 1 && $urandom_range(9) == 0) n = $urandom_range(len - 1);
    else if ($urandom_range(9) == 0) n = len + $urandom_range(2, 1);
    else n = len;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) program_from_pool(4'($urandom_range(NUM_ENTRIES - 1)));
      issue(mk_data(8'($urandom_range(255))));
    end
  endtask

  task automatic random_burst();
    int pick;
    pick = $urandom_range(99);
    if (pick < 58) send_packet();
    else if (pick < 70) program_from_pool(4'($urandom_range(NUM_ENTRIES - 1)));
    else if (pick < 78) issue(mk_data(8'($urandom_range(255))));
    else if (pick < 86) issue(mk_op(pmbw_pkg::OP_HEADER));
    else if (pick < 91) issue(mk_op(OP_UNUSED));
    else if (pick < 96) issue(mk_op(pmbw_pkg::OP_PROGRAM));
    else begin
      issue(mk_header(pool_src[$urandom_range(7)], pool_dst[$urandom_range(7)],
                      $urandom_range(BUFFER_BYTES - 8), 16'($urandom_range(8))));
      repeat ($urandom_range(4)) issue(mk_data(8'($urandom_range(255))));
    end
  endtask

  task automatic run_traffic(input int target);
    int base;
    int seg;
    base = sent_reqs;
    seg  = -1;
    while (sent_reqs - base < target) begin
      if ((sent_reqs - base) / 64 != seg) begin
        seg = (sent_reqs - base) / 64;
        case ($urandom_range(2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      random_burst();
    end
  endtask

  task automatic test_after_reset();
    issue(mk_header(16'h0000, 16'h0000, 32'd0, 16'd0));
    issue(mk_data(8'hFF));
    issue(mk_op(OP_UNUSED));
  endtask

  task automatic test_table_program();
    issue(mk_program(4'd0, 1'b1, 16'hFFFF, 16'h0000));
    issue(mk_program(4'd15, 1'b1, 16'h1234, 16'hFFFF));
    issue(mk_program(4'd3, 1'b1, 16'h1234, 16'hFFFF));
    issue(mk_program(4'd7, 1'b0, 16'hAAAA, 16'h5555));
  endtask

  task automatic test_header_cases();
    issue(mk_header(16'hAAAA, 16'h5555, 32'd0, 16'd1));
    issue(mk_header(16'h1234, 16'hFFFF, 32'hFFFF_FFFF, 16'd1));
    issue(mk_header(16'h1234, 16'hFFFF, 32'd0, 16'hFFFF));
    issue(mk_header(16'hFFFF, 16'h0000, 32'd1024, 16'd0));
    issue(mk_data(8'h5A));
    issue(mk_header(16'hFFFF, 16'h0000, 32'd1022, 16'd2));
    issue(mk_data(8'h00));
    issue(mk_data(8'hFF));
    issue(mk_data(8'hA5));
    issue(mk_header(16'h1234, 16'hFFFF, 32'd5, 16'd3));
    issue(mk_data(8'h11));
    issue(mk_program(4'd3, 1'b0, 16'h1234, 16'hFFFF));
    issue(mk_data(8'h22));
    issue(mk_header(16'h0001, 16'h0002, 32'd0, 16'd4));
    issue(mk_data(8'h33));
  endtask

  task automatic test_random_traffic(input int target);
    pool_src = '{16'h0000, 16'hFFFF, 16'h0050, 16'h01BB, 16'h8000, 16'h1F90,
                 16'h0050, 16'h7FFF};
    pool_dst = '{16'hFFFF, 16'h0000, 16'hC350, 16'h0050, 16'h0001, 16'h1F90,
                 16'hE000, 16'h0050};
    for (int i = 0; i < NUM_ENTRIES; i++) program_from_pool(i[3:0]);
    run_traffic(target);
  endtask

  task automatic test_pause_drain();
    send_packet();
    wait_drained();
    send_packet();
  endtask

  task automatic test_back_to_back(input int target);
    gaps_on = 1'b0;
    run_traffic(target);
  endtask

  initial begin
    gaps_on = 1'b1;
    gap_pct = 20;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_table_program();
    test_header_cases();
    test_random_traffic(500);
    test_pause_drain();
    test_random_traffic(500);
    test_back_to_back(200);
    wait_drained();
    repeat (HDR_LATENCY + 15) @(posedge clk);
    if (err_cnt == 0 && exp_res_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
